[hdl/crs_pkg.sv]
// crs_pkg: shared constants, types and permutation tables for the cramer solver
// no dependencies; imported by crs_front, crs_back, the top and the testbench
package crs_pkg;

  localparam int ORDER  = 4;
  localparam int IDX_W  = 2;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;

  function automatic int fact(input int n);
    int r;
    r = 1;
    for (int k = 2; k <= n; k++) r = r * k;
    return r;
  endfunction

  localparam int NPERM  = fact(ORDER);
  localparam int PERM_W = $clog2(NPERM);
  localparam int LIMB_W = $clog2(ORDER);
  localparam int KD_W   = $clog2(ORDER + 1);
  // exact determinant width, with headroom for the sum of all terms
  localparam int DET_W  = VAL_W * ORDER + 8;
  localparam int NUM_W  = DET_W + FRAC_W;
  localparam int DCNT_W = $clog2(NUM_W);

  localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
  localparam logic [1:0] CMD_LOAD_RHS = 2'd1;
  localparam logic [1:0] CMD_SOLVE    = 2'd2;

  typedef logic [ORDER-1:0][IDX_W-1:0] perm_row_t;
  typedef perm_row_t [NPERM-1:0] perm_tab_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // all permutations in lexicographic order
  function automatic perm_tab_t make_perms();
    int a [ORDER];
    perm_tab_t t;
    int x, y, tmp, lo, hi;
    for (int k = 0; k < ORDER; k++) a[k] = k;
    for (int p = 0; p < NPERM; p++) begin
      for (int k = 0; k < ORDER; k++) t[p][k] = IDX_W'(a[k]);
      x = ORDER - 2;
      while (x >= 0 && a[x] >= a[x+1]) x--;
      if (x >= 0) begin
        y = ORDER - 1;
        while (a[y] <= a[x]) y--;
        tmp = a[x]; a[x] = a[y]; a[y] = tmp;
        lo = x + 1;
        hi = ORDER - 1;
        while (lo < hi) begin
          tmp = a[lo]; a[lo] = a[hi]; a[hi] = tmp;
          lo++;
          hi--;
        end
      end
    end
    return t;
  endfunction

  // odd permutation -> 1
  function automatic logic [NPERM-1:0] make_parity(input perm_tab_t t);
    logic [NPERM-1:0] r;
    int inv;
    for (int p = 0; p < NPERM; p++) begin
      inv = 0;
      for (int u = 0; u < ORDER; u++)
        for (int v = u + 1; v < ORDER; v++)
          if (t[p][u] > t[p][v]) inv++;
      r[p] = inv[0];
    end
    return r;
  endfunction

  localparam perm_tab_t        PERMS  = make_perms();
  localparam logic [NPERM-1:0] PARITY = make_parity(PERMS);

endpackage

[hdl/crs_ram.sv]
// crs_ram: generic single-write, single-read ram with registered read data
// no dependencies
module crs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[hdl/crs_front.sv]
// crs_front: input beat acceptance, command classification and a two-entry queue
// depends on crs_pkg
module crs_front
  import crs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       s_tuser,
  input  logic [39:0]      s_tdata,
  output queue_head_t      head,
  input  logic             pop
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;
  item_t      in_item;

  assign in_item.kind  = s_tuser;
  assign in_item.row   = s_tdata[1:0];
  assign in_item.col   = s_tdata[3:2];
  assign in_item.value = s_tdata[35:4];

  // drop unknown commands and indices beyond the matrix order
  always_comb begin
    case (s_tuser)
      CMD_LOAD_MAT: keep = (int'(in_item.row) < ORDER) && (int'(in_item.col) < ORDER);
      CMD_LOAD_RHS: keep = (int'(in_item.row) < ORDER);
      CMD_SOLVE:    keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready && keep;
  assign head.valid = (count != 2'd0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[hdl/crs_back.sv]
// crs_back: stores, determinant sequencer, restoring divider and output register
// depends on crs_pkg and crs_ram
module crs_back
  import crs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  queue_head_t       head,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [IDX_W-1:0]  out_index,
  output logic [VAL_W-1:0]  out_solution,
  output logic              out_singular,
  output logic              out_saturated,
  output logic              m_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_DET  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ORDER - 1);
  localparam logic [LIMB_W-1:0] LAST_LIMB = LIMB_W'(ORDER - 1);
  localparam logic [PERM_W-1:0] LAST_PERM = PERM_W'(NPERM - 1);
  localparam logic [KD_W-1:0]   LAST_KD   = KD_W'(ORDER);
  // product magnitude preset to one
  localparam logic [ORDER-1:0][VAL_W-1:0] MAG_ONE = (ORDER*VAL_W)'(1);

  logic [2:0]                    state;
  logic [KD_W-1:0]               kd;
  logic [PERM_W-1:0]             p;
  logic [IDX_W-1:0]              i;
  logic [LIMB_W-1:0]             j;
  logic [ORDER-1:0][VAL_W-1:0]   mag;
  logic [VAL_W-1:0]              carry;
  logic                          psign;
  logic [DET_W-1:0]              acc;
  logic [DET_W-1:0]              dmain;
  logic                          sing;
  logic                          neg;
  logic [NUM_W-1:0]              num;
  logic [DET_W-1:0]              den;
  logic [DET_W-1:0]              rem;
  logic [VAL_W-1:0]              q;
  logic                          hi;
  logic [DCNT_W-1:0]             dcnt;
  logic [VAL_W-1:0]              res_sol;
  logic                          res_sat;

  logic [VAL_W-1:0]  mat_rdata;
  logic [VAL_W-1:0]  rhs_rdata;
  logic [IDX_W-1:0]  pcol;
  logic [KD_W-1:0]   kcol;
  logic              use_rhs;
  logic [VAL_W-1:0]  elem;
  logic [VAL_W-1:0]  emag;
  logic [63:0]       mprod;
  logic [DET_W-1:0]  term;
  logic [DET_W-1:0]  acc_abs;
  logic [DET_W-1:0]  dmain_abs;
  logic [DET_W:0]    rem_sh;
  logic [DET_W:0]    rem_diff;
  logic              ge;
  logic [VAL_W-1:0]  limit;
  logic [PERM_W-1:0] p_inc;
  logic              out_free;
  logic              load_mat;
  logic              load_rhs;

  assign pop      = (state == ST_IDLE) && head.valid;
  assign load_mat = pop && (head.item.kind == CMD_LOAD_MAT);
  assign load_rhs = pop && (head.item.kind == CMD_LOAD_RHS);

  assign pcol = PERMS[p][i];

  crs_ram #(.WIDTH(VAL_W), .DEPTH(16)) u_mat (
    .clk   (clk),
    .we    (load_mat),
    .waddr ({head.item.row, head.item.col}),
    .wdata (head.item.value),
    .raddr ({i, pcol}),
    .rdata (mat_rdata)
  );

  crs_ram #(.WIDTH(VAL_W), .DEPTH(4)) u_rhs (
    .clk   (clk),
    .we    (load_rhs),
    .waddr (head.item.row),
    .wdata (head.item.value),
    .raddr (i),
    .rdata (rhs_rdata)
  );

  always_comb begin
    kcol      = kd - KD_W'(1);
    use_rhs   = (kd != '0) && (KD_W'(pcol) == kcol);
    elem      = use_rhs ? rhs_rdata : mat_rdata;
    emag      = elem[VAL_W-1] ? (~elem + VAL_W'(1)) : elem;
    mprod     = 64'(mag[j]) * 64'(emag) + 64'(carry);
    term      = DET_W'(mag);
    acc_abs   = acc[DET_W-1] ? (~acc + DET_W'(1)) : acc;
    dmain_abs = dmain[DET_W-1] ? (~dmain + DET_W'(1)) : dmain;
    rem_sh    = {rem, num[NUM_W-1]};
    rem_diff  = rem_sh - {1'b0, den};
    ge        = !rem_diff[DET_W];
    limit     = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    p_inc     = p + PERM_W'(1);
    out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (pop && head.item.kind == CMD_SOLVE) begin
            kd       <= '0;
            p        <= '0;
            i        <= '0;
            j        <= '0;
            carry    <= '0;
            mag      <= MAG_ONE;
            psign    <= PARITY[0];
            acc      <= '0;
            state    <= ST_READ;
          end
        end
        ST_READ: begin
          j     <= '0;
          carry <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          mag[j] <= mprod[31:0];
          carry  <= mprod[63:32];
          if (j == LAST_LIMB) begin
            psign <= psign ^ elem[VAL_W-1];
            if (i == LAST_IDX) begin
              state <= ST_ADD;
            end else begin
              i     <= i + IDX_W'(1);
              state <= ST_READ;
            end
          end else begin
            j <= j + LIMB_W'(1);
          end
        end
        ST_ADD: begin
          acc <= psign ? (acc - term) : (acc + term);
          if (p == LAST_PERM) begin
            state <= ST_DET;
          end else begin
            p      <= p_inc;
            i      <= '0;
            mag    <= MAG_ONE;
            psign  <= PARITY[p_inc];
            state  <= ST_READ;
          end
        end
        ST_DET: begin
          if (kd == '0) begin
            dmain <= acc;
            sing  <= (acc == '0);
            kd    <= KD_W'(1);
            if (acc == '0) begin
              res_sol <= '0;
              res_sat <= 1'b0;
              state   <= ST_EMIT;
            end else begin
              acc    <= '0;
              p      <= '0;
              i      <= '0;
              mag    <= MAG_ONE;
              psign  <= PARITY[0];
              state  <= ST_READ;
            end
          end else begin
            neg   <= acc[DET_W-1] ^ dmain[DET_W-1];
            num   <= {acc_abs, {FRAC_W{1'b0}}};
            den   <= dmain_abs;
            rem   <= '0;
            q     <= '0;
            hi    <= 1'b0;
            dcnt  <= DCNT_W'(NUM_W - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= ge ? rem_diff[DET_W-1:0] : rem_sh[DET_W-1:0];
          num  <= {num[NUM_W-2:0], 1'b0};
          hi   <= hi | q[VAL_W-1];
          q    <= {q[VAL_W-2:0], ge};
          dcnt <= dcnt - DCNT_W'(1);
          if (dcnt == '0) state <= ST_FIN;
        end
        ST_FIN: begin
          if (hi || q > limit) begin
            res_sol <= limit;
            res_sat <= 1'b1;
          end else begin
            res_sol <= neg ? (~q + VAL_W'(1)) : q;
            res_sat <= 1'b0;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (kd == LAST_KD) begin
              state <= ST_IDLE;
            end else begin
              kd <= kd + KD_W'(1);
              if (!sing) begin
                acc    <= '0;
                p      <= '0;
                i      <= '0;
                mag    <= MAG_ONE;
                psign  <= PARITY[0];
                state  <= ST_READ;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_index     <= IDX_W'(kcol);
      out_solution  <= res_sol;
      out_singular  <= sing;
      out_saturated <= res_sat;
      m_tlast       <= (kd == LAST_KD);
    end
  end

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_singular |-> out_solution == '0 && !out_saturated)
    else $error("singular beat with nonzero solution");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tlast == (out_index == LAST_IDX))
    else $error("last flag not on final unknown");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE)
    else $error("queue popped while solve in progress");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_saturated |->
      out_solution == 32'h7FFF_FFFF || out_solution == 32'h8000_0000)
    else $error("saturated beat not at a range limit");

endmodule

[hdl/cramer_rule_solver_4x4_top.sv]
// cramer_rule_solver_4x4_top: cramer's rule linear solver, q16.16 in and out
// depends on crs_pkg, crs_front, crs_back (which uses crs_ram)
//
//  channel  | dir | signals                          | per beat
//  ---------+-----+----------------------------------+----------------------------------
//  s_       | in  | tvalid tready tuser tdata        | load matrix / rhs entry, or solve
//  m_       | out | tvalid tready tuser tdata tlast  | one unknown of a solve
//
//  load beats are taken from the queue by the back end while idle; the front queue holds two beats
//  a nonsingular solve forms ORDER+1 exact determinants over all ORDER! permutations,
//  each term built with one 32x32 multiply per limb, and then makes ORDER divides;
//  a singular solve forms only the main determinant and emits zero solutions
//  the shared 32x32 multiplier and the one-bit-per-cycle divider set the solve time
//  rst is synchronous; stores hold junk until written, no clearing pass
//  input keeps being accepted while the queue has room, even with a result stalled
module cramer_rule_solver_4x4_top
  import crs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // command
  input  logic [39:0] s_tdata,   // row[1:0], col[3:2], value[35:4], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // singular[0], saturated[1]
  output logic [39:0] m_tdata,   // unknown_index[1:0], solution[33:2], zero pad
  output logic        m_tlast
);

  queue_head_t      head;
  logic             pop;
  logic [IDX_W-1:0] out_index;
  logic [VAL_W-1:0] out_solution;
  logic             out_singular;
  logic             out_saturated;

  // front: accept, classify, queue
  crs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .head     (head),
    .pop      (pop)
  );

  // back: stores, determinants, divides, output register
  crs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_index     (out_index),
    .out_solution  (out_solution),
    .out_singular  (out_singular),
    .out_saturated (out_saturated),
    .m_tlast       (m_tlast)
  );

  assign m_tdata = {6'd0, out_solution, out_index};
  assign m_tuser = {out_saturated, out_singular};

endmodule

[test/cramer_rule_solver_4x4_top_tb.sv]
// cramer_rule_solver_4x4_top_tb: stream testbench for the cramer's rule solver
// depends on crs_pkg and cramer_rule_solver_4x4_top; self-checking with an exact predictor
module cramer_rule_solver_4x4_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crs_pkg::*;

  // command code that the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic signed [287:0] det_t;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] sol;
    logic        sing;
    logic        sat;
    logic        lst;
  } unknown_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
  } entry_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [1:0]  m_tuser;
  logic [39:0] m_tdata;
  logic        m_tlast;

  cramer_rule_solver_4x4_top dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // predictor state: a copy of both stores
  logic [31:0] mat_copy [4][4];
  logic [31:0] rhs_copy [4];
  unknown_t    pending_unknowns [$];
  int          errors = 0;
  bit          idle_on = 1;
  int          out_stall = 0;

  function automatic det_t ent(logic [31:0] v);
    return det_t'($signed(v));
  endfunction

  function automatic det_t det3(logic [31:0] m [4][4], int r0, int c0, int c1, int c2);
    det_t a, b, c;
    a = ent(m[r0][c0]) * (ent(m[r0+1][c1]) * ent(m[r0+2][c2])
                          - ent(m[r0+1][c2]) * ent(m[r0+2][c1]));
    b = ent(m[r0][c1]) * (ent(m[r0+1][c0]) * ent(m[r0+2][c2])
                          - ent(m[r0+1][c2]) * ent(m[r0+2][c0]));
    c = ent(m[r0][c2]) * (ent(m[r0+1][c0]) * ent(m[r0+2][c1])
                          - ent(m[r0+1][c1]) * ent(m[r0+2][c0]));
    return a - b + c;
  endfunction

  // cofactor expansion along row 0
  function automatic det_t det4(logic [31:0] m [4][4]);
    return ent(m[0][0]) * det3(m, 1, 1, 2, 3) - ent(m[0][1]) * det3(m, 1, 0, 2, 3)
         + ent(m[0][2]) * det3(m, 1, 0, 1, 3) - ent(m[0][3]) * det3(m, 1, 0, 1, 2);
  endfunction

  task automatic predict_beat(entry_t e);
    logic [31:0] work [4][4];
    det_t d, dk, q;
    unknown_t u;
    case (e.cmd)
      CMD_LOAD_MAT: mat_copy[e.row][e.col] = e.value;
      CMD_LOAD_RHS: rhs_copy[e.row] = e.value;
      CMD_SOLVE: begin
        d = det4(mat_copy);
        for (int k = 0; k < ORDER; k++) begin
          u.idx = k[1:0];
          u.lst = (k == ORDER - 1);
          u.sing = (d == 0);
          u.sat = 1'b0;
          u.sol = '0;
          if (d != 0) begin
            work = mat_copy;
            for (int r = 0; r < ORDER; r++) work[r][k] = rhs_copy[r];
            dk = det4(work);
            q = (dk <<< FRAC_W) / d;   // truncates toward zero
            if (q > det_t'(32'sh7FFFFFFF)) begin
              u.sol = 32'h7FFFFFFF;
              u.sat = 1'b1;
            end else if (q < -det_t'(64'sh80000000)) begin
              u.sol = 32'h80000000;
              u.sat = 1'b1;
            end else begin
              u.sol = q[31:0];
            end
          end
          pending_unknowns.push_back(u);
        end
      end
      default: ;  // command three does nothing
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // result side: random backpressure bursts
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      m_tready = 0;
    end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 2);
      m_tready = 0;
    end else begin
      m_tready = 1;
    end
  end

  // checker: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    unknown_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_unknowns.size() == 0) begin
        report("unexpected beat", 64'(m_tdata), 64'(0));
      end else begin
        w = pending_unknowns.pop_front();
        if (m_tdata[1:0] != w.idx)
          report("unknown_index", 64'(m_tdata[1:0]), 64'(w.idx));
        if (m_tdata[33:2] != w.sol)
          report("solution", 64'(m_tdata[33:2]), 64'(w.sol));
        if (m_tdata[39:34] != 0) report("pad", 64'(m_tdata[39:34]), 64'(0));
        if (m_tuser[0] != w.sing) report("singular", 64'(m_tuser[0]), 64'(w.sing));
        if (m_tuser[1] != w.sat) report("saturated", 64'(m_tuser[1]), 64'(w.sat));
        if (m_tlast != w.lst) report("tlast", 64'(m_tlast), 64'(w.lst));
      end
    end
  end

  task automatic send(entry_t e);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = e.cmd;
    s_tdata = {4'b0, e.value, e.col, e.row};
    do @(posedge clk); while (!s_tready);
    predict_beat(e);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 16)) - 8) << 16;
      2: return 32'($signed($urandom_range(0, 4096)) - 2048) << 8;
      3: return '0;
      4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  entry_t directed [$];

  initial begin
    entry_t e;
    int sent;
    // identity system with extreme right-hand side: x equals b
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        directed.push_back('{CMD_LOAD_MAT, r[1:0], c[1:0], (r == c) ? 32'h10000 : 32'h0});
    directed.push_back('{CMD_LOAD_RHS, 2'd0, 2'd3, 32'h7FFFFFFF});
    directed.push_back('{CMD_LOAD_RHS, 2'd1, 2'd0, 32'h80000000});
    directed.push_back('{CMD_LOAD_RHS, 2'd2, 2'd0, 32'hFFFFFFFF});
    directed.push_back('{CMD_LOAD_RHS, 2'd3, 2'd1, 32'h00000001});
    directed.push_back('{CMD_SOLVE, 2'd0, 2'd0, 32'h0});
    // tiny determinant: the first quotient saturates
    directed.push_back('{CMD_LOAD_MAT, 2'd0, 2'd0, 32'h00000001});
    directed.push_back('{CMD_SOLVE, 2'd3, 2'd3, 32'hFFFFFFFF});
    // zero row: singular system, then command three is ignored
    directed.push_back('{CMD_LOAD_MAT, 2'd0, 2'd0, 32'h0});
    directed.push_back('{CMD_UNUSED, 2'd3, 2'd3, 32'hFFFFFFFF});
    directed.push_back('{CMD_SOLVE, 2'd0, 2'd0, 32'h0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    foreach (directed[i]) send(directed[i]);

    // random part: mostly reloads of a few entries followed by a solve
    sent = 0;
    while (sent < 330) begin
      if (sent > 280) idle_on = 0;
      repeat ($urandom_range(1, 6)) begin
        e.cmd = $urandom_range(0, 9) == 0 ? CMD_UNUSED
              : ($urandom_range(0, 3) == 0 ? CMD_LOAD_RHS : CMD_LOAD_MAT);
        e.row = 2'($urandom);
        e.col = 2'($urandom);
        e.value = rand_value();
        send(e);
        sent++;
      end
      e.cmd = CMD_SOLVE;
      e.row = 2'($urandom);
      e.col = 2'($urandom);
      e.value = $urandom;
      send(e);
      sent++;
    end
    s_tvalid = 0;
    while (pending_unknowns.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("[cramer_rule_solver_4x4_top] OK");
    else $display("[cramer_rule_solver_4x4_top] ERROR");
    $finish;
  end

  // generous limit: about 80 solves plus stalls
  initial begin
    #40ms;
    $display("[cramer_rule_solver_4x4_top] ERROR");
    $finish;
  end

endmodule

[sim.f]
hdl/crs_pkg.sv
hdl/crs_ram.sv
hdl/crs_front.sv
hdl/crs_back.sv
hdl/cramer_rule_solver_4x4_top.sv
test/cramer_rule_solver_4x4_top_tb.sv
